@@ design/sfd_pkg.sv @@
// Shared types and constants for the stereo feedback delay.
// Holds the configuration register codes, their widths and reset values, and the Q1.15 constants.
// No dependencies.
package sfd_pkg;

  // Configuration register codes.
  localparam int CFG_INDEX_BITS = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DELAY    = 4'd0,
    REG_FEEDBACK = 4'd1,
    REG_WET      = 4'd2,
    REG_DRY      = 4'd3
  } cfg_reg_t;

  // Register widths. The write data is as wide as the widest register.
  localparam int DELAY_BITS    = 17;
  localparam int FEEDBACK_BITS = 15;
  localparam int GAIN_BITS     = 16;
  localparam int CFG_DATA_BITS = DELAY_BITS;

  // Q1.15 arithmetic.
  localparam int Q15_FRAC = 15;
  localparam logic [GAIN_BITS-1:0] Q15_UNITY = 16'd32768;
  localparam logic [FEEDBACK_BITS-1:0] FEEDBACK_MAX = 15'd31129;
  localparam int Q15_HALF = 16384;

  // Register reset values.
  localparam int DELAY_RESET = 13230;
  localparam logic [FEEDBACK_BITS-1:0] FEEDBACK_RESET = 15'd11469;
  localparam logic [GAIN_BITS-1:0] WET_RESET = 16'd11469;
  localparam logic [GAIN_BITS-1:0] DRY_RESET = 16'd32768;

endpackage

@@ design/sfd_ram.sv @@
// Generic simple dual-port RAM: one write port and one read port with a registered read.
// The read data holds its value when no read is enabled.
// No dependencies.
module sfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/sfd_mac.sv @@
// Two-term Q1.15 multiply-accumulate with round-half-up and saturation to the sample width.
// Computes sat((x * gain_x + d * gain_d + half) >>> 15).
// Depends on sfd_pkg.
module sfd_mac
  import sfd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic        [GAIN_BITS-1:0]   gain_x,
  input  logic signed [SAMPLE_BITS-1:0] d,
  input  logic        [GAIN_BITS-1:0]   gain_d,
  output logic signed [SAMPLE_BITS-1:0] y
);

  localparam int AccBits = SAMPLE_BITS + GAIN_BITS + 2;
  localparam logic signed [AccBits-1:0] SatMax = (AccBits'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [AccBits-1:0] SatMin = -SatMax - 1;

  logic signed [AccBits-1:0] prod_x;
  logic signed [AccBits-1:0] prod_d;
  logic signed [AccBits-1:0] acc;
  logic signed [AccBits-1:0] q;

  // Both products, the rounding offset, then a floor shift.
  always_comb begin
    prod_x = x * $signed({1'b0, gain_x});
    prod_d = d * $signed({1'b0, gain_d});
    acc    = prod_x + prod_d + AccBits'(Q15_HALF);
    q      = acc >>> Q15_FRAC;
  end

  // Clamp to the sample range.
  always_comb begin
    if (q > SatMax) begin
      y = SAMPLE_BITS'(SatMax);
    end else if (q < SatMin) begin
      y = SAMPLE_BITS'(SatMin);
    end else begin
      y = SAMPLE_BITS'(q);
    end
  end

endmodule

@@ design/stereo_feedback_delay.sv @@
// Stereo feedback delay (echo): top level with configuration registers, pipeline and delay line.
// Depends on sfd_pkg, sfd_ram (shared left/right delay line) and sfd_mac (Q1.15 datapath).
//
// Channel  Handshake                    Payload
// s_*      s_tvalid / s_tready          s_tdata: left_in, right_in
// m_*      m_tvalid / m_tready          m_tdata: left_out, right_out
// cfg_*    cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One stereo frame per cycle while the output is not stalled; an accepted frame passes the
// delay line read register, then the output register.
// The delay line is a single RAM of both channels with one read and one write port per cycle;
// a read of the entry written on the same edge is forwarded from the datapath.
// After reset the line reads as zero wherever it has not yet been written since reset,
// tracked by the write pointer and a wrap flag, so no clearing pass is needed.
// A stalled output holds the frame in the output register and one more in the read stage.
module stereo_feedback_delay
  import sfd_pkg::*;
#(
  parameter int DEPTH       = 131072,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // Input frames.
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // s_tdata: left_in, right_in (zero padded to whole bytes)
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
  // Output frames.
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // m_tdata: left_out, right_out (zero padded to whole bytes)
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        m_tdata,
  // Configuration writes.
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]                 cfg_index,
  input  logic [CFG_DATA_BITS-1:0]                  cfg_data
);

  localparam int TdataBits  = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int AddrBits   = $clog2(DEPTH);
  localparam int CmpBits    = ((AddrBits > DELAY_BITS) ? AddrBits : DELAY_BITS) + 1;
  localparam int DelayReset = (DELAY_RESET >= DEPTH) ? DEPTH - 1 : DELAY_RESET;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Configuration registers, held already clamped.
  logic [AddrBits-1:0]      delay_eff;
  logic [FEEDBACK_BITS-1:0] feedback_gain;
  logic [GAIN_BITS-1:0]     wet_gain;
  logic [GAIN_BITS-1:0]     dry_gain;

  logic [AddrBits-1:0]      delay_next;
  logic [FEEDBACK_BITS-1:0] feedback_next;
  logic [GAIN_BITS-1:0]     wet_next;
  logic [GAIN_BITS-1:0]     dry_next;

  // Write pointer and fill tracking.
  logic [AddrBits-1:0] wp;
  logic [AddrBits-1:0] wp_next;
  logic                wrapped;
  logic [AddrBits-1:0] rd_addr;
  logic [AddrBits:0]   rd_wide;
  logic                rd_written;

  // Read stage registers.
  logic                s1_valid;
  sample_t             s1_left;
  sample_t             s1_right;
  logic [AddrBits-1:0] s1_wp;
  logic                s1_written;
  logic                s1_fwd;
  sample_t             s1_fwd_left;
  sample_t             s1_fwd_right;
  logic                s1_adv;
  logic                s_accept;
  logic                fwd_hit;

  // Datapath.
  logic [2*SAMPLE_BITS-1:0] ram_rdata;
  sample_t                  del_left;
  sample_t                  del_right;
  sample_t                  st_left;
  sample_t                  st_right;
  sample_t                  out_left;
  sample_t                  out_right;
  sample_t                  m_left;
  sample_t                  m_right;

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign s1_adv    = !m_tvalid || m_tready;
  assign s_tready  = !s1_valid || s1_adv;
  assign s_accept  = s_tvalid && s_tready;

  // Clamp written values into their legal ranges.
  always_comb begin
    if (cfg_data == '0) begin
      delay_next = AddrBits'(1);
    end else if (CmpBits'(cfg_data) >= CmpBits'(DEPTH)) begin
      delay_next = AddrBits'(DEPTH - 1);
    end else begin
      delay_next = AddrBits'(cfg_data);
    end
    feedback_next = (cfg_data[FEEDBACK_BITS-1:0] > FEEDBACK_MAX) ?
                    FEEDBACK_MAX : cfg_data[FEEDBACK_BITS-1:0];
    wet_next = (cfg_data[GAIN_BITS-1:0] > Q15_UNITY) ? Q15_UNITY : cfg_data[GAIN_BITS-1:0];
    dry_next = wet_next;
  end

  // Configuration register file; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_eff     <= AddrBits'(DelayReset);
      feedback_gain <= FEEDBACK_RESET;
      wet_gain      <= WET_RESET;
      dry_gain      <= DRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELAY:    delay_eff     <= delay_next;
        REG_FEEDBACK: feedback_gain <= feedback_next;
        REG_WET:      wet_gain      <= wet_next;
        REG_DRY:      dry_gain      <= dry_next;
        default: ;
      endcase
    end
  end

  // Read address behind the write pointer, modulo the line depth.
  always_comb begin
    if (wp >= delay_eff) begin
      rd_wide = {1'b0, wp} - {1'b0, delay_eff};
    end else begin
      rd_wide = {1'b0, wp} + (AddrBits+1)'(DEPTH) - {1'b0, delay_eff};
    end
    rd_addr    = rd_wide[AddrBits-1:0];
    rd_written = wrapped || (rd_addr < wp);
    wp_next    = (wp == AddrBits'(DEPTH - 1)) ? '0 : wp + AddrBits'(1);
    fwd_hit    = s1_valid && s1_adv && (s1_wp == rd_addr);
  end

  // Write pointer advances once per accepted frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
    end else if (s_accept) begin
      wp <= wp_next;
      if (wp == AddrBits'(DEPTH - 1)) begin
        wrapped <= 1'b1;
      end
    end
  end

  // Read stage: holds the frame while its delayed samples are fetched.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_left      <= s_tdata[SAMPLE_BITS-1:0];
      s1_right     <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      s1_wp        <= wp;
      s1_written   <= rd_written;
      s1_fwd       <= fwd_hit;
      s1_fwd_left  <= st_left;
      s1_fwd_right <= st_right;
    end
  end

  // Shared delay line, left in the low half.
  sfd_ram #(
    .WIDTH(2*SAMPLE_BITS),
    .DEPTH(DEPTH)
  ) u_line (
    .clk  (clk),
    .we   (s1_valid && s1_adv),
    .waddr(s1_wp),
    .wdata({st_right, st_left}),
    .re   (s_accept),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  // Delayed samples: forwarded, read back, or zero where never written.
  always_comb begin
    if (s1_fwd) begin
      del_left  = s1_fwd_left;
      del_right = s1_fwd_right;
    end else if (s1_written) begin
      del_left  = ram_rdata[SAMPLE_BITS-1:0];
      del_right = ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end else begin
      del_left  = '0;
      del_right = '0;
    end
  end

  // Feedback values to store.
  sfd_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_store_left (
    .x(s1_left), .gain_x(Q15_UNITY), .d(del_left),
    .gain_d(GAIN_BITS'(feedback_gain)), .y(st_left)
  );

  sfd_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_store_right (
    .x(s1_right), .gain_x(Q15_UNITY), .d(del_right),
    .gain_d(GAIN_BITS'(feedback_gain)), .y(st_right)
  );

  // Dry and wet mix for the outputs.
  sfd_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_out_left (
    .x(s1_left), .gain_x(dry_gain), .d(del_left), .gain_d(wet_gain), .y(out_left)
  );

  sfd_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_out_right (
    .x(s1_right), .gain_x(dry_gain), .d(del_right), .gain_d(wet_gain), .y(out_right)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      m_left  <= out_left;
      m_right <= out_right;
    end
  end

  assign m_tdata = TdataBits'({m_right, m_left});

  // A stalled output with a full read stage must block new frames.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while the pipeline is full");

  // The pointer moves only on an accepted frame.
  assert property (@(posedge clk) disable iff (rst)
    !s_accept |=> $stable(wp))
    else $error("write pointer moved without a frame");

  // The read never targets the entry about to be written.
  assert property (@(posedge clk) disable iff (rst)
    s_accept |-> rd_addr != wp)
    else $error("zero delay read");

  // A new output frame only comes from the read stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s1_valid))
    else $error("output frame without a source");

endmodule
